// File: sv/rcpm_pkg.sv
// ----------------------------------------------------------------------------
// rcpm_pkg
// Shared constants and types for the rounded corner pixel mask.
// ----------------------------------------------------------------------------
package rcpm_pkg;

    localparam int COORD_BITS = 12;              // column/row counter width
    localparam int CFG_BITS   = 12;              // widest config register
    localparam int PIX_BITS   = 24;
    localparam int DELTA_BITS = COORD_BITS + 1;  // 2R-2c-1 term
    localparam int SQ_BITS    = 2 * DELTA_BITS;
    localparam int SUM_BITS   = SQ_BITS + 1;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_CORNER_RADIUS = 2'd2,
        CFG_PIXEL_FORMAT  = 2'd3
    } t_cfg_index;

    // frame geometry seen by the corner test
    typedef struct packed {
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic [COORD_BITS-1:0] radius;   // already clamped
    } t_geom;

endpackage

// File: sv/rounded_corner_pixel_mask.sv
// ----------------------------------------------------------------------------
// rounded_corner_pixel_mask
// Blacks out pixels outside a quarter circle in each corner of a raster frame.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_pixel_in, i_frame_start
//  output    out        o_out_valid / i_out_ready   o_pixel_out, o_masked,
//                                                   o_frame_end
//  config    in         i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
//  One pixel per clock unless the output stalls, through a four-register
//  pipeline (position, corner mirror, squares, result). Synchronous
//  active-low reset restores W=128, H=32, radius 0, RGB24 and clears the
//  counters. The whole pipeline holds while a result waits and i_out_ready
//  is low; bubbles move forward otherwise.
// ----------------------------------------------------------------------------
module rounded_corner_pixel_mask (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  rcpm_pkg::t_cfg_index          i_cfg_index,
    input  logic [rcpm_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rcpm_pkg::PIX_BITS-1:0] i_pixel_in,
    input  logic                          i_frame_start,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rcpm_pkg::PIX_BITS-1:0] o_pixel_out,
    output logic                          o_masked,
    output logic                          o_frame_end
);
    import rcpm_pkg::*;

    logic [COORD_BITS-1:0] r_width, r_height, r_radius_req, r_radius;
    logic                  r_format;
    logic [COORD_BITS-1:0] r_col, r_row;

    logic [COORD_BITS-1:0] n_col, n_row, n_radius, smaller;
    logic [COORD_BITS-1:0] cur_x, cur_y;
    logic [COORD_BITS:0]   x_inc, y_inc;
    logic                  last_col, last_row;
    logic [PIX_BITS-1:0]   n_pix;

    logic                  r_v1, r_v2, r_v3, r_vo;
    logic [PIX_BITS-1:0]   r_pix1, r_pix2, r_pix3;
    logic                  r_end1, r_end2, r_end3;
    logic [COORD_BITS-1:0] r_x1, r_y1;
    logic [PIX_BITS-1:0]   r_pix_out;
    logic                  r_masked, r_end_out;

    logic   en, take, outside;
    t_geom  geom;

    assign en         = !r_vo || i_out_ready;
    assign o_in_ready = en;
    assign take       = i_in_valid && en;

    // clamp radius to half the smaller side; zero side gives zero
    always_comb begin
        smaller  = (r_width < r_height) ? r_width : r_height;
        n_radius = (r_radius_req < (smaller >> 1)) ? r_radius_req : (smaller >> 1);
    end

    always_comb begin
        cur_x    = i_frame_start ? '0 : r_col;
        cur_y    = i_frame_start ? '0 : r_row;
        x_inc    = {1'b0, cur_x} + (COORD_BITS+1)'(1);
        y_inc    = {1'b0, cur_y} + (COORD_BITS+1)'(1);
        last_col = x_inc >= {1'b0, r_width};
        last_row = y_inc >= {1'b0, r_height};
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : y_inc[COORD_BITS-1:0];
        end else begin
            n_col = x_inc[COORD_BITS-1:0];
            n_row = cur_y;
        end
        n_pix = r_format ? {8'h00, i_pixel_in[15:0]} : i_pixel_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= COORD_BITS'(128);
            r_height     <= COORD_BITS'(32);
            r_radius_req <= '0;
            r_format     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:   r_width      <= i_cfg_data[COORD_BITS-1:0];
                CFG_FRAME_HEIGHT:  r_height     <= i_cfg_data[COORD_BITS-1:0];
                CFG_CORNER_RADIUS: r_radius_req <= i_cfg_data[COORD_BITS-1:0];
                CFG_PIXEL_FORMAT:  r_format     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_vo     <= 1'b0;
        end else begin
            r_radius <= n_radius;
            if (take) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (en) begin
                r_v1 <= i_in_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pix1    <= n_pix;
            r_end1    <= last_col && last_row;
            r_x1      <= cur_x;
            r_y1      <= cur_y;
            r_pix2    <= r_pix1;
            r_end2    <= r_end1;
            r_pix3    <= r_pix2;
            r_end3    <= r_end2;
            r_pix_out <= outside ? '0 : r_pix3;
            r_masked  <= outside;
            r_end_out <= r_end3;
        end
    end

    assign geom.width  = r_width;
    assign geom.height = r_height;
    assign geom.radius = r_radius;

    rcpm_corner_test u_corner (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_x       (r_x1),
        .i_y       (r_y1),
        .i_geom    (geom),
        .o_outside (outside)
    );

    assign o_out_valid = r_vo;
    assign o_pixel_out = r_pix_out;
    assign o_masked    = r_masked;
    assign o_frame_end = r_end_out;

endmodule

// File: sv/rcpm_corner_test.sv
// ----------------------------------------------------------------------------
// rcpm_corner_test
// Two-stage corner test: mirror to corner coordinates, square, compare.
// ----------------------------------------------------------------------------
module rcpm_corner_test (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rcpm_pkg::COORD_BITS-1:0] i_x,
    input  logic [rcpm_pkg::COORD_BITS-1:0] i_y,
    input  rcpm_pkg::t_geom                 i_geom,
    output logic                            o_outside
);
    import rcpm_pkg::*;

    logic [COORD_BITS-1:0] n_cx, n_cy;
    logic                  n_band;
    logic [DELTA_BITS-1:0] n_dx, n_dy, n_r2;

    logic [DELTA_BITS-1:0] r_dx, r_dy, r_r2;
    logic                  r_band;
    logic [SQ_BITS-1:0]    r_sqx, r_sqy, r_lim;
    logic                  r_band2;

    logic x_in, x_lo, x_hi, y_in, y_lo, y_hi;

    always_comb begin
        x_in = i_x < i_geom.width;
        x_lo = i_x < i_geom.radius;
        x_hi = i_x >= (i_geom.width - i_geom.radius);
        y_in = i_y < i_geom.height;
        y_lo = i_y < i_geom.radius;
        y_hi = i_y >= (i_geom.height - i_geom.radius);

        n_cx = x_lo ? i_x : (i_geom.width - i_x - COORD_BITS'(1));
        n_cy = y_lo ? i_y : (i_geom.height - i_y - COORD_BITS'(1));

        n_band = (i_geom.radius != '0) && x_in && (x_lo || x_hi)
                 && y_in && (y_lo || y_hi);

        // out-of-band values wrap; they are dropped by the band flag
        n_r2 = {i_geom.radius, 1'b0};
        n_dx = n_r2 - {n_cx, 1'b0} - DELTA_BITS'(1);
        n_dy = n_r2 - {n_cy, 1'b0} - DELTA_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_r2    <= n_r2;
            r_band  <= n_band;
            r_sqx   <= SQ_BITS'(r_dx) * SQ_BITS'(r_dx);
            r_sqy   <= SQ_BITS'(r_dy) * SQ_BITS'(r_dy);
            r_lim   <= SQ_BITS'(r_r2) * SQ_BITS'(r_r2);
            r_band2 <= r_band;
        end
    end

    assign o_outside = r_band2 &&
        ((SUM_BITS'(r_sqx) + SUM_BITS'(r_sqy)) > SUM_BITS'(r_lim));

endmodule
